/* rtl/vgu_pkg.sv */
// ----------------------------------------------------------------------------
// vgu_pkg: shared types and helpers for the 2D vector geometry unit
// Fixed-point format, item and result layouts, and saturation helper.
// ----------------------------------------------------------------------------
package vgu_pkg;

  localparam int unsigned WIDTH     = 32;
  localparam int unsigned FRAC_BITS = 16;

  // magnitude of a difference of two components
  localparam int unsigned ROOT_W = WIDTH + 1;
  // sum of two squares of ROOT_W-bit magnitudes
  localparam int unsigned PROD_W = 2 * ROOT_W;
  // squared length of b and dot product magnitude
  localparam int unsigned NORM_W = 2 * WIDTH;
  // projection coefficient, below 2^(WIDTH+FRAC_BITS)
  localparam int unsigned QUO_W  = WIDTH + FRAC_BITS;
  localparam int unsigned HALF_W = QUO_W / 2;
  localparam int unsigned PX_W   = WIDTH + 2;
  localparam int unsigned SAT_W  = WIDTH + 4;

  typedef enum logic [1:0] {
    KIND_DECOMP  = 2'd0,
    KIND_REFLECT = 2'd1,
    KIND_NORM    = 2'd2,
    KIND_DIST    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [WIDTH-1:0]  ax;
    logic signed [WIDTH-1:0]  ay;
    logic signed [WIDTH-1:0]  bx;
    logic signed [WIDTH-1:0]  by;
  } item_t;

  typedef struct packed {
    logic [NORM_W-1:0] dotm;
    logic              dneg;
    logic [NORM_W-1:0] n;
    logic              zf;
    logic              uf;
  } side_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // divider lane: numerator bits shift out of lq while quotient bits shift in
  typedef struct packed {
    logic [NORM_W-1:0] den;
    logic [NORM_W-1:0] rem;
    logic [QUO_W-1:0]  lq;
  } lane_t;

  typedef struct packed {
    logic              dneg;
    logic              zf;
    logic              uf;
    logic [ROOT_W-1:0] root;
  } ctl_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] ux;
    logic signed [WIDTH-1:0] uy;
    logic signed [WIDTH-1:0] vx;
    logic signed [WIDTH-1:0] vy;
    logic [WIDTH-1:0]        scalar;
    status_e                 status;
  } res_t;

  function automatic logic [WIDTH-1:0] mag(input logic signed [WIDTH-1:0] v);
    mag = v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // returns {saturated, value}
  function automatic logic [WIDTH:0] sat_s(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-WIDTH:0] top;
    top = v[SAT_W-1:WIDTH-1];
    if (top == '0 || top == '1) begin
      sat_s = {1'b0, v[WIDTH-1:0]};
    end else if (v[SAT_W-1]) begin
      sat_s = {1'b1, 1'b1, {(WIDTH-1){1'b0}}};
    end else begin
      sat_s = {1'b1, 1'b0, {(WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

/* rtl/vgu_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// vgu_sqrt_cell: one bit of the floor square root chain
// Decides root bit BIT by a trial subtract and hands the item to the next cell.
// ----------------------------------------------------------------------------
module vgu_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  vgu_pkg::item_t  item_i,
  input  vgu_pkg::side_t  side_i,
  input  vgu_pkg::sq_t    sq_i,
  output logic            valid_o,
  output vgu_pkg::item_t  item_o,
  output vgu_pkg::side_t  side_o,
  output vgu_pkg::sq_t    sq_o
);

  localparam int unsigned TW = vgu_pkg::PROD_W + 2;

  logic [TW-1:0]  trial;
  logic [TW-1:0]  rem_x;
  logic           take;
  logic           valid_q;
  vgu_pkg::item_t item_q;
  vgu_pkg::side_t side_q;
  vgu_pkg::sq_t   sq_d, sq_q;

  // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
  assign trial = (TW'(sq_i.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign rem_x = TW'(sq_i.rem);
  assign take  = trial <= rem_x;

  always_comb begin
    sq_d = sq_i;
    if (take) begin
      sq_d.rem  = vgu_pkg::PROD_W'(rem_x - trial);
      sq_d.root = sq_i.root | (vgu_pkg::ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      side_q <= side_i;
      sq_q   <= sq_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign side_o  = side_q;
  assign sq_o    = sq_q;

endmodule

/* rtl/vgu_div_cell.sv */
// ----------------------------------------------------------------------------
// vgu_div_cell: one quotient bit of two restoring divider lanes
// Shifts in the next numerator bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module vgu_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  vgu_pkg::item_t  item_i,
  input  vgu_pkg::ctl_t   ctl_i,
  input  vgu_pkg::lane_t  lane_a_i,
  input  vgu_pkg::lane_t  lane_b_i,
  output logic            valid_o,
  output vgu_pkg::item_t  item_o,
  output vgu_pkg::ctl_t   ctl_o,
  output vgu_pkg::lane_t  lane_a_o,
  output vgu_pkg::lane_t  lane_b_o
);

  function automatic vgu_pkg::lane_t step(input vgu_pkg::lane_t l);
    logic [vgu_pkg::NORM_W:0] t;
    logic                     ge;
    vgu_pkg::lane_t           r;
    t     = {l.rem, l.lq[vgu_pkg::QUO_W-1]};
    ge    = t >= {1'b0, l.den};
    r.den = l.den;
    r.rem = ge ? vgu_pkg::NORM_W'(t - {1'b0, l.den}) : t[vgu_pkg::NORM_W-1:0];
    r.lq  = {l.lq[vgu_pkg::QUO_W-2:0], ge};
    step  = r;
  endfunction

  logic           valid_q;
  vgu_pkg::item_t item_q;
  vgu_pkg::ctl_t  ctl_q;
  vgu_pkg::lane_t lane_a_q, lane_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q   <= item_i;
      ctl_q    <= ctl_i;
      lane_a_q <= step(lane_a_i);
      lane_b_q <= step(lane_b_i);
    end
  end

  assign valid_o  = valid_q;
  assign item_o   = item_q;
  assign ctl_o    = ctl_q;
  assign lane_a_o = lane_a_q;
  assign lane_b_o = lane_b_q;

endmodule

/* rtl/vgu_back.sv */
// ----------------------------------------------------------------------------
// vgu_back: projection scaling and result formatting
// Splits b times the coefficient into partial products, then saturates.
// ----------------------------------------------------------------------------
module vgu_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  vgu_pkg::item_t               item_i,
  input  vgu_pkg::ctl_t                ctl_i,
  input  logic [vgu_pkg::QUO_W-1:0]    dm_i,
  input  logic [vgu_pkg::FRAC_BITS:0]  qy_i,
  output logic                         valid_o,
  output vgu_pkg::res_t                res_o
);

  localparam int unsigned W  = vgu_pkg::WIDTH;
  localparam int unsigned F  = vgu_pkg::FRAC_BITS;
  localparam int unsigned H  = vgu_pkg::HALF_W;
  localparam int unsigned PW = W + H;
  localparam int unsigned FW = W + vgu_pkg::QUO_W;

  // stage 1: partial products
  logic [W-1:0]   bxm, bym;
  logic [H-1:0]   dm_lo, dm_hi;
  logic           v1_q;
  vgu_pkg::item_t item1_q;
  vgu_pkg::ctl_t  ctl1_q;
  logic [F:0]     qx1_q, qy1_q;
  logic [PW-1:0]  pxl_q, pxh_q, pyl_q, pyh_q;

  assign bxm   = vgu_pkg::mag(item_i.bx);
  assign bym   = vgu_pkg::mag(item_i.by);
  assign dm_lo = dm_i[H-1:0];
  assign dm_hi = dm_i[vgu_pkg::QUO_W-1:H];

  // stage 2: signed projection components
  logic [FW-1:0]                    fx, fy;
  logic signed [vgu_pkg::PX_W-1:0]  pmx, pmy, px_d, py_d;
  logic                             negx, negy;
  logic                             v2_q;
  vgu_pkg::item_t                   item2_q;
  vgu_pkg::ctl_t                    ctl2_q;
  logic [F:0]                       qx2_q, qy2_q;
  logic signed [vgu_pkg::PX_W-1:0]  px2_q, py2_q;

  assign fx   = {pxh_q, {H{1'b0}}} + FW'(pxl_q);
  assign fy   = {pyh_q, {H{1'b0}}} + FW'(pyl_q);
  assign pmx  = vgu_pkg::PX_W'(fx[F+W-1:F]);
  assign pmy  = vgu_pkg::PX_W'(fy[F+W-1:F]);
  assign negx = item1_q.bx[W-1] ^ ctl1_q.dneg;
  assign negy = item1_q.by[W-1] ^ ctl1_q.dneg;
  assign px_d = negx ? -pmx : pmx;
  assign py_d = negy ? -pmy : pmy;

  // stage 3: output formatting
  logic                              v3_q;
  vgu_pkg::res_t                     res_d, res_q;
  logic signed [vgu_pkg::SAT_W-1:0]  px_e, py_e, ax_e, ay_e;
  logic [W:0]                        s_ux, s_uy, s_vx, s_vy;
  logic [W-1:0]                      qxe, qye;
  logic                              sat;

  assign px_e = vgu_pkg::SAT_W'(px2_q);
  assign py_e = vgu_pkg::SAT_W'(py2_q);
  assign ax_e = vgu_pkg::SAT_W'(item2_q.ax);
  assign ay_e = vgu_pkg::SAT_W'(item2_q.ay);
  assign qxe  = W'(qx2_q);
  assign qye  = W'(qy2_q);

  always_comb begin
    res_d = '0;
    sat   = 1'b0;
    s_ux  = '0;
    s_uy  = '0;
    s_vx  = '0;
    s_vy  = '0;
    unique case (item2_q.kind)
      vgu_pkg::KIND_DECOMP, vgu_pkg::KIND_REFLECT: begin
        if (ctl2_q.zf) begin
          res_d.status = vgu_pkg::ST_ZERO;
        end else begin
          if (item2_q.kind == vgu_pkg::KIND_DECOMP) begin
            s_ux = vgu_pkg::sat_s(px_e);
            s_uy = vgu_pkg::sat_s(py_e);
            s_vx = vgu_pkg::sat_s(ax_e - px_e);
            s_vy = vgu_pkg::sat_s(ay_e - py_e);
          end else begin
            s_ux = vgu_pkg::sat_s(px_e + px_e - ax_e);
            s_uy = vgu_pkg::sat_s(py_e + py_e - ay_e);
          end
          res_d.ux = s_ux[W-1:0];
          res_d.uy = s_uy[W-1:0];
          res_d.vx = s_vx[W-1:0];
          res_d.vy = s_vy[W-1:0];
          sat      = s_ux[W] | s_uy[W] | s_vx[W] | s_vy[W];
        end
      end
      vgu_pkg::KIND_NORM: begin
        if (ctl2_q.zf) begin
          res_d.status = vgu_pkg::ST_ZERO;
        end else if (ctl2_q.uf) begin
          // unit length passes a through
          res_d.ux     = item2_q.ax;
          res_d.uy     = item2_q.ay;
          res_d.scalar = W'(1) << F;
        end else begin
          res_d.ux     = item2_q.ax[W-1] ? (~qxe + 1'b1) : qxe;
          res_d.uy     = item2_q.ay[W-1] ? (~qye + 1'b1) : qye;
          res_d.scalar = ctl2_q.root[W-1:0];
        end
      end
      vgu_pkg::KIND_DIST: begin
        if (ctl2_q.root[W]) begin
          res_d.scalar = '1;
          sat          = 1'b1;
        end else begin
          res_d.scalar = ctl2_q.root[W-1:0];
        end
      end
    endcase
    if (sat) begin
      res_d.status = vgu_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item1_q <= item_i;
      ctl1_q  <= ctl_i;
      qx1_q   <= dm_i[F:0];
      qy1_q   <= qy_i;
      pxl_q   <= PW'(bxm) * PW'(dm_lo);
      pxh_q   <= PW'(bxm) * PW'(dm_hi);
      pyl_q   <= PW'(bym) * PW'(dm_lo);
      pyh_q   <= PW'(bym) * PW'(dm_hi);
      item2_q <= item1_q;
      ctl2_q  <= ctl1_q;
      qx2_q   <= qx1_q;
      qy2_q   <= qy1_q;
      px2_q   <= px_d;
      py2_q   <= py_d;
      res_q   <= res_d;
    end
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;

endmodule

/* rtl/vector2_geometry_unit.sv */
// ----------------------------------------------------------------------------
// vector2_geometry_unit: signed fixed-point 2D vector geometry
// Decompose, reflect, normalize and distance on a stream of vector pairs.
// ----------------------------------------------------------------------------
// items pass stages f1, f2, the root and divider chains, vgu_back and output register
// throughput: one item per cycle while the skid stage is empty, set by a 33-cell
//   square root chain and a 48-cell quotient chain that take a new item each cycle
// an output register with a skid stage takes one result under stall; a full skid stalls input
// reset clears only the valid flags of the pipeline, output and skid stage
module vector2_geometry_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [4*vgu_pkg::WIDTH-1:0] s_axis_tdata,  // ax, ay, bx, by
  input  logic [1:0]                  s_axis_tuser,  // kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [5*vgu_pkg::WIDTH-1:0] m_axis_tdata,  // ux, uy, vx, vy, scalar
  output logic [1:0]                  m_axis_tuser   // status
);

  localparam int unsigned W  = vgu_pkg::WIDTH;
  localparam int unsigned F  = vgu_pkg::FRAC_BITS;
  localparam int unsigned RW = vgu_pkg::ROOT_W;
  localparam int unsigned QW = vgu_pkg::QUO_W;
  localparam int unsigned NW = vgu_pkg::NORM_W;
  localparam int unsigned PW = vgu_pkg::PROD_W;

  logic en;

  // ---------------- stage f1: squares and products ----------------
  vgu_pkg::item_t     item_in;
  logic [W-1:0]       axm, aym, bxm, bym;
  logic signed [W:0]  dxs, dys;
  logic [RW-1:0]      dxm, dym, x1, y1, x2, y2;

  logic               f1_valid_q;
  vgu_pkg::item_t     f1_item_q;
  logic [PW-1:0]      f1_m0_q, f1_m1_q;
  logic [NW-1:0]      f1_m2_q, f1_m3_q;
  logic               f1_s1_q, f1_s2_q;

  assign item_in.kind = vgu_pkg::kind_e'(s_axis_tuser);
  assign item_in.ax   = s_axis_tdata[W-1:0];
  assign item_in.ay   = s_axis_tdata[2*W-1:W];
  assign item_in.bx   = s_axis_tdata[3*W-1:2*W];
  assign item_in.by   = s_axis_tdata[4*W-1:3*W];

  assign axm = vgu_pkg::mag(item_in.ax);
  assign aym = vgu_pkg::mag(item_in.ay);
  assign bxm = vgu_pkg::mag(item_in.bx);
  assign bym = vgu_pkg::mag(item_in.by);
  assign dxs = (W+1)'(item_in.bx) - (W+1)'(item_in.ax);
  assign dys = (W+1)'(item_in.by) - (W+1)'(item_in.ay);
  assign dxm = dxs[W] ? (~dxs + 1'b1) : dxs;
  assign dym = dys[W] ? (~dys + 1'b1) : dys;

  always_comb begin
    unique case (item_in.kind)
      vgu_pkg::KIND_DECOMP, vgu_pkg::KIND_REFLECT: begin
        x1 = RW'(axm);
        y1 = RW'(bxm);
        x2 = RW'(aym);
        y2 = RW'(bym);
      end
      vgu_pkg::KIND_NORM: begin
        x1 = RW'(axm);
        y1 = RW'(axm);
        x2 = RW'(aym);
        y2 = RW'(aym);
      end
      vgu_pkg::KIND_DIST: begin
        x1 = dxm;
        y1 = dxm;
        x2 = dym;
        y2 = dym;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_item_q <= item_in;
      f1_m0_q   <= PW'(x1) * PW'(y1);
      f1_m1_q   <= PW'(x2) * PW'(y2);
      f1_m2_q   <= NW'(bxm) * NW'(bxm);
      f1_m3_q   <= NW'(bym) * NW'(bym);
      f1_s1_q   <= item_in.ax[W-1] ^ item_in.bx[W-1];
      f1_s2_q   <= item_in.ay[W-1] ^ item_in.by[W-1];
    end
  end

  // ---------------- stage f2: sums, signed dot product ----------------
  logic [PW-1:0]   sum_s;
  logic [NW-1:0]   d0, d1;
  vgu_pkg::side_t  side_d;
  vgu_pkg::sq_t    sq_d;

  logic            f2_valid_q;
  vgu_pkg::item_t  f2_item_q;
  vgu_pkg::side_t  f2_side_q;
  vgu_pkg::sq_t    f2_sq_q;

  assign sum_s = f1_m0_q + f1_m1_q;
  assign d0    = f1_m0_q[NW-1:0];
  assign d1    = f1_m1_q[NW-1:0];

  always_comb begin
    side_d.n = f1_m2_q + f1_m3_q;
    if (f1_s1_q == f1_s2_q) begin
      side_d.dotm = d0 + d1;
      side_d.dneg = f1_s1_q;
    end else if (d0 >= d1) begin
      side_d.dotm = d0 - d1;
      side_d.dneg = f1_s1_q;
    end else begin
      side_d.dotm = d1 - d0;
      side_d.dneg = f1_s2_q;
    end
    side_d.zf = (f1_item_q.kind == vgu_pkg::KIND_NORM) ? (sum_s == '0) : (side_d.n == '0);
    side_d.uf = sum_s == (PW'(1) << (2 * F));
    sq_d.rem  = sum_s;
    sq_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (en) begin
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_item_q <= f1_item_q;
      f2_side_q <= side_d;
      f2_sq_q   <= sq_d;
    end
  end

  // ---------------- square root chain ----------------
  logic            sv_v    [0:RW];
  vgu_pkg::item_t  sv_item [0:RW];
  vgu_pkg::side_t  sv_side [0:RW];
  vgu_pkg::sq_t    sv_sq   [0:RW];

  assign sv_v[0]    = f2_valid_q;
  assign sv_item[0] = f2_item_q;
  assign sv_side[0] = f2_side_q;
  assign sv_sq[0]   = f2_sq_q;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    vgu_sqrt_cell #(
      .BIT (RW - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv_v[j]),
      .item_i  (sv_item[j]),
      .side_i  (sv_side[j]),
      .sq_i    (sv_sq[j]),
      .valid_o (sv_v[j+1]),
      .item_o  (sv_item[j+1]),
      .side_o  (sv_side[j+1]),
      .sq_o    (sv_sq[j+1])
    );
  end

  // ---------------- divider chain ----------------
  logic            dv_v    [0:QW];
  vgu_pkg::item_t  dv_item [0:QW];
  vgu_pkg::ctl_t   dv_ctl  [0:QW];
  vgu_pkg::lane_t  dv_a    [0:QW];
  vgu_pkg::lane_t  dv_b    [0:QW];

  vgu_pkg::item_t  si;
  vgu_pkg::side_t  ss;
  logic [RW-1:0]   root;
  vgu_pkg::ctl_t   ctl_in;
  vgu_pkg::lane_t  lane_a_in, lane_b_in;

  assign si   = sv_item[RW];
  assign ss   = sv_side[RW];
  assign root = sv_sq[RW].root;

  always_comb begin
    ctl_in.dneg = ss.dneg;
    ctl_in.zf   = ss.zf;
    ctl_in.uf   = ss.uf;
    ctl_in.root = root;
    if (si.kind == vgu_pkg::KIND_NORM) begin
      lane_a_in.den = NW'(root);
      lane_a_in.rem = '0;
      lane_a_in.lq  = {vgu_pkg::mag(si.ax), {F{1'b0}}};
    end else begin
      // numerator is dot * 2^F; its part above the quotient width starts the remainder
      lane_a_in.den = ss.n;
      lane_a_in.rem = NW'(ss.dotm[NW-1:W]);
      lane_a_in.lq  = {ss.dotm[W-1:0], {F{1'b0}}};
    end
    lane_b_in.den = NW'(root);
    lane_b_in.rem = '0;
    lane_b_in.lq  = {vgu_pkg::mag(si.ay), {F{1'b0}}};
  end

  assign dv_v[0]    = sv_v[RW];
  assign dv_item[0] = si;
  assign dv_ctl[0]  = ctl_in;
  assign dv_a[0]    = lane_a_in;
  assign dv_b[0]    = lane_b_in;

  for (genvar k = 0; k < QW; k++) begin : g_div
    vgu_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (dv_v[k]),
      .item_i   (dv_item[k]),
      .ctl_i    (dv_ctl[k]),
      .lane_a_i (dv_a[k]),
      .lane_b_i (dv_b[k]),
      .valid_o  (dv_v[k+1]),
      .item_o   (dv_item[k+1]),
      .ctl_o    (dv_ctl[k+1]),
      .lane_a_o (dv_a[k+1]),
      .lane_b_o (dv_b[k+1])
    );
  end

  // ---------------- scaling and formatting ----------------
  logic           b_valid;
  vgu_pkg::res_t  b_res;

  vgu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v[QW]),
    .item_i  (dv_item[QW]),
    .ctl_i   (dv_ctl[QW]),
    .dm_i    (dv_a[QW].lq),
    .qy_i    (dv_b[QW].lq[F:0]),
    .valid_o (b_valid),
    .res_o   (b_res)
  );

  // ---------------- output register and skid stage ----------------
  logic           out_valid_q, skid_valid_q;
  vgu_pkg::res_t  out_q, skid_q;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= b_valid;
      end else if (b_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_valid_q || m_axis_tready) begin
        out_q <= b_res;
      end else begin
        skid_q <= b_res;
      end
    end else if (m_axis_tready) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.scalar, out_q.vy, out_q.vx, out_q.uy, out_q.ux};
  assign m_axis_tuser  = out_q.status;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid stage filled without a stalled output");

  a_zero_dir_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == vgu_pkg::ST_ZERO) |->
      (out_q.ux == '0 && out_q.uy == '0 && out_q.vx == '0 && out_q.vy == '0 &&
       out_q.scalar == '0))
    else $error("zero direction result carries nonzero fields");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector2_geometry_unit
// Drives directed and random vector pairs over the input stream, predicts
// every result in a scoreboard and compares it with each output transfer.
// ----------------------------------------------------------------------------
typedef struct {
  logic [31:0] ux;
  logic [31:0] uy;
  logic [31:0] vx;
  logic [31:0] vy;
  logic [31:0] scalar;
  logic [1:0]  status;
} geo_result_t;

class geo_scoreboard;
  geo_result_t pending[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  static function longint unsigned abs64(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  static function logic [31:0] clamp_s(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  static function logic [127:0] floor_root(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  // component times signed coefficient, truncated toward zero
  static function longint scale_comp(input longint c, input longint unsigned dm,
                                     input bit dneg);
    longint unsigned p;
    p = (abs64(c) * dm) >> vgu_pkg::FRAC_BITS;
    return ((c < 0) != dneg) ? -longint'(p) : longint'(p);
  endfunction

  static function geo_result_t compute(input vgu_pkg::kind_e k, input logic [31:0] ax,
                                       input logic [31:0] ay, input logic [31:0] bx,
                                       input logic [31:0] by);
    geo_result_t       r;
    bit                sat;
    longint            sax, say, sbx, sby, p1, p2, px, py;
    longint unsigned   n, m1, m2, dotm, dm, qx, qy, axm, aym;
    bit                dneg;
    logic [127:0]      wide, len;
    r = '{default: '0};
    sat = 1'b0;
    sax = longint'(signed'(ax));
    say = longint'(signed'(ay));
    sbx = longint'(signed'(bx));
    sby = longint'(signed'(by));
    case (k)
      vgu_pkg::KIND_DECOMP, vgu_pkg::KIND_REFLECT: begin
        n = abs64(sbx) * abs64(sbx) + abs64(sby) * abs64(sby);
        if (n == 0) begin
          r.status = vgu_pkg::ST_ZERO;
        end else begin
          p1 = sax * sbx;
          p2 = say * sby;
          m1 = abs64(p1);
          m2 = abs64(p2);
          if ((p1 < 0) == (p2 < 0)) begin
            dotm = m1 + m2;
            dneg = p1 < 0;
          end else if (m1 >= m2) begin
            dotm = m1 - m2;
            dneg = p1 < 0;
          end else begin
            dotm = m2 - m1;
            dneg = p2 < 0;
          end
          wide = ({64'd0, dotm} << vgu_pkg::FRAC_BITS) / {64'd0, n};
          dm = wide[63:0];
          if (dm == 0) dneg = 1'b0;
          px = scale_comp(sbx, dm, dneg);
          py = scale_comp(sby, dm, dneg);
          if (k == vgu_pkg::KIND_DECOMP) begin
            r.ux = clamp_s(px, sat);
            r.uy = clamp_s(py, sat);
            r.vx = clamp_s(sax - px, sat);
            r.vy = clamp_s(say - py, sat);
          end else begin
            r.ux = clamp_s(2 * px - sax, sat);
            r.uy = clamp_s(2 * py - say, sat);
          end
        end
      end
      vgu_pkg::KIND_NORM: begin
        axm = abs64(sax);
        aym = abs64(say);
        wide = {64'd0, axm} * {64'd0, axm} + {64'd0, aym} * {64'd0, aym};
        if (wide == 0) begin
          r.status = vgu_pkg::ST_ZERO;
        end else if (wide == (128'd1 << (2 * vgu_pkg::FRAC_BITS))) begin
          // unit length passes the subject through
          r.ux = ax;
          r.uy = ay;
          r.scalar = 32'd1 << vgu_pkg::FRAC_BITS;
        end else begin
          len = floor_root(wide);
          qx = (axm << vgu_pkg::FRAC_BITS) / len[63:0];
          qy = (aym << vgu_pkg::FRAC_BITS) / len[63:0];
          r.ux = clamp_s((sax < 0) ? -longint'(qx) : longint'(qx), sat);
          r.uy = clamp_s((say < 0) ? -longint'(qy) : longint'(qy), sat);
          if (len > 128'hffff_ffff) begin
            sat = 1'b1;
            r.scalar = 32'hffff_ffff;
          end else begin
            r.scalar = len[31:0];
          end
        end
      end
      default: begin
        axm = abs64(sbx - sax);
        aym = abs64(sby - say);
        wide = {64'd0, axm} * {64'd0, axm} + {64'd0, aym} * {64'd0, aym};
        len = floor_root(wide);
        if (len > 128'hffff_ffff) begin
          sat = 1'b1;
          r.scalar = 32'hffff_ffff;
        end else begin
          r.scalar = len[31:0];
        end
      end
    endcase
    if (sat && r.status == vgu_pkg::ST_OK) r.status = vgu_pkg::ST_SAT;
    return r;
  endfunction

  function void note_input(input vgu_pkg::kind_e k, input logic [31:0] ax,
                           input logic [31:0] ay, input logic [31:0] bx,
                           input logic [31:0] by);
    pending.push_back(compute(k, ax, ay, bx, by));
  endfunction

  function void check_result(input geo_result_t got);
    geo_result_t want;
    if (pending.size() == 0) begin
      $error("unexpected result transfer");
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.ux !== want.ux) begin
      $error("ux expected %h actual %h", want.ux, got.ux);
      errors++;
    end
    if (got.uy !== want.uy) begin
      $error("uy expected %h actual %h", want.uy, got.uy);
      errors++;
    end
    if (got.vx !== want.vx) begin
      $error("vx expected %h actual %h", want.vx, got.vx);
      errors++;
    end
    if (got.vy !== want.vy) begin
      $error("vy expected %h actual %h", want.vy, got.vy);
      errors++;
    end
    if (got.scalar !== want.scalar) begin
      $error("scalar expected %h actual %h", want.scalar, got.scalar);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status expected %h actual %h", want.status, got.status);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [127:0] s_data = '0;
  logic [1:0]   s_user = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [159:0] m_data;
  logic [1:0]   m_user;

  int unsigned  send_idle = 0;
  int unsigned  recv_idle = 0;
  logic         hold_go = 1'b0;
  int unsigned  hold_left = 0;

  geo_scoreboard sb = new();

  vector2_geometry_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go && hold_left == 0) begin
      hold_left <= 400;
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // both handshakes are sampled mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    geo_result_t got;
    if (rst_ni && s_valid && s_ready)
      sb.note_input(vgu_pkg::kind_e'(s_user), s_data[31:0], s_data[63:32],
                    s_data[95:64], s_data[127:96]);
    if (rst_ni && m_valid && m_ready) begin
      got.ux     = m_data[31:0];
      got.uy     = m_data[63:32];
      got.vx     = m_data[95:64];
      got.vy     = m_data[127:96];
      got.scalar = m_data[159:128];
      got.status = m_user;
      sb.check_result(got);
    end
  end

  task automatic send_vec(input vgu_pkg::kind_e k, input logic [31:0] ax,
                          input logic [31:0] ay, input logic [31:0] bx,
                          input logic [31:0] by);
    bit taken;
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= k;
    s_data  <= {by, bx, ay, ax};
    do begin
      @(negedge clk_i);
      taken = s_ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(3))
      0: return v;
      1: return {{16{v[31]}}, v[15:0]};
      2: return {{24{v[31]}}, v[7:0]} <<< $urandom_range(16);
      default: return {{4{v[31]}}, v[27:0]};
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    vgu_pkg::kind_e k;
    for (int i = 0; i < count; i++) begin
      k = vgu_pkg::kind_e'($urandom_range(3));
      if ($urandom_range(19) == 0)
        send_vec(k, rand_comp(), rand_comp(), 32'd0, 32'd0);
      else
        send_vec(k, rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    s_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 17;
    recv_idle = 51;
    for (int k = 0; k < 4; k++) begin
      // zero direction or zero subject
      send_vec(vgu_pkg::kind_e'(k), 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
      send_vec(vgu_pkg::kind_e'(k), 32'd0, 32'd0, 32'h0003_0000, 32'hfffc_0000);
      // full-scale values, where saturation shows up
      send_vec(vgu_pkg::kind_e'(k), 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff);
      send_vec(vgu_pkg::kind_e'(k), 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001,
               32'h0000_0001);
      send_vec(vgu_pkg::kind_e'(k), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000);
    end
    // unit subject passes through
    send_vec(vgu_pkg::KIND_NORM, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
    send_vec(vgu_pkg::KIND_NORM, 32'd0, 32'hffff_0000, 32'd5, 32'd7);
    // tiny subject still normalizes to a unit vector
    send_vec(vgu_pkg::KIND_NORM, 32'd1, 32'd0, 32'd0, 32'd0);
    send_vec(vgu_pkg::KIND_DECOMP, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'd0);
    send_vec(vgu_pkg::KIND_REFLECT, 32'hfffd_0000, 32'h0004_0000, 32'h0001_0000,
             32'h0001_0000);
    send_random(180);
    drain();

    send_idle = 51;
    recv_idle = 17;
    send_random(200);
    drain();

    send_idle = 0;
    recv_idle = 0;
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    send_random(220);
    drain();

    repeat (120) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
